// ===== rtl/stxr_pkg.sv =====
package stxr_pkg;

    // frame delimiters
    localparam logic [7:0] START_BYTE = 8'h02;
    localparam logic [7:0] END_BYTE   = 8'h03;

    // largest payload accepted in one frame (1 to 255)
    localparam int unsigned MAX_PAYLOAD = 255;

    // receiver phase, as reported on the phase output
    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_LENGTH = 3'd1,
        PH_DATA   = 3'd2,
        PH_CHECK  = 3'd3,
        PH_END    = 3'd4,
        PH_DONE   = 3'd5,
        PH_ERROR  = 3'd6
    } phase_t;

endpackage

// ===== rtl/stx_etx_frame_receiver_core.sv =====
// channel | direction | handshake           | word contents
// --------+-----------+---------------------+-------------------------------------------
// in      | input     | in_valid / in_stall  | mode, rx_byte
// out     | output    | out_valid / out_stall| frame_complete, frame_error, payload_valid,
//         |           |                     | payload_byte, payload_index, phase
//
// one word in, one word out; a new word can be taken on every cycle while in_stall is low
// a word passes the input register, then the parser update into the result register
// out_stall holds the result register and, through it, the input register
// rst_n clears both valid flags and returns the parser to wait for start

module stx_etx_frame_receiver_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       mode,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       frame_complete,
    output logic       frame_error,
    output logic       payload_valid,
    output logic [7:0] payload_byte,
    output logic [7:0] payload_index,
    output logic [2:0] phase
);

    localparam logic [7:0] MAX_LEN = 8'(stxr_pkg::MAX_PAYLOAD);

    // input register
    logic       in_valid_reg;
    logic       in_mode_reg;
    logic [7:0] in_byte_reg;

    // parser state
    stxr_pkg::phase_t phase_reg, phase_next;
    logic [7:0] exp_len_reg, exp_len_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] csum_reg, csum_next;

    // result register
    logic       out_valid_reg;
    logic       pvalid_reg, pvalid_next;
    logic [7:0] pbyte_reg, pbyte_next;
    logic [7:0] pindex_reg, pindex_next;

    logic       out_advance;
    logic       step;
    logic [7:0] count_inc;

    // result register moves when empty or taken
    assign out_advance = !out_valid_reg || !out_stall;
    assign step        = in_valid_reg && out_advance;
    assign in_stall    = in_valid_reg && !out_advance;

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_mode_reg <= mode;
            in_byte_reg <= rx_byte;
        end
    end

    assign count_inc = count_reg + 8'd1;

    // parser next state and result
    always_comb
    begin
        phase_next   = phase_reg;
        exp_len_next = exp_len_reg;
        count_next   = count_reg;
        csum_next    = csum_reg;
        pvalid_next  = 1'b0;
        pbyte_next   = 8'd0;
        pindex_next  = 8'd0;
        if (in_mode_reg)
        begin
            phase_next   = stxr_pkg::PH_START;
            exp_len_next = 8'd0;
            count_next   = 8'd0;
            csum_next    = 8'd0;
        end
        else
        begin
            case (phase_reg)
                stxr_pkg::PH_START:
                begin
                    if (in_byte_reg == stxr_pkg::START_BYTE)
                    begin
                        csum_next  = in_byte_reg;
                        phase_next = stxr_pkg::PH_LENGTH;
                    end
                end
                stxr_pkg::PH_LENGTH:
                begin
                    exp_len_next = in_byte_reg;
                    count_next   = 8'd0;
                    csum_next    = csum_reg ^ in_byte_reg;
                    phase_next   = (in_byte_reg == 8'd0) ? stxr_pkg::PH_CHECK
                                                         : stxr_pkg::PH_DATA;
                end
                stxr_pkg::PH_DATA:
                begin
                    if (count_reg < MAX_LEN)
                    begin
                        pvalid_next = 1'b1;
                        pbyte_next  = in_byte_reg;
                        pindex_next = count_reg;
                        count_next  = count_inc;
                        csum_next   = csum_reg ^ in_byte_reg;
                        if (count_inc >= exp_len_reg)
                        begin
                            phase_next = stxr_pkg::PH_CHECK;
                        end
                    end
                    else
                    begin
                        phase_next = stxr_pkg::PH_ERROR;
                    end
                end
                stxr_pkg::PH_CHECK:
                begin
                    phase_next = (csum_reg == in_byte_reg) ? stxr_pkg::PH_END
                                                           : stxr_pkg::PH_ERROR;
                end
                stxr_pkg::PH_END:
                begin
                    phase_next = (in_byte_reg == stxr_pkg::END_BYTE) ? stxr_pkg::PH_DONE
                                                                     : stxr_pkg::PH_ERROR;
                end
                stxr_pkg::PH_DONE:
                begin
                    phase_next = stxr_pkg::PH_DONE;
                end
                default:
                begin
                    phase_next = stxr_pkg::PH_ERROR;
                end
            endcase
        end
    end

    // parser state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= stxr_pkg::PH_START;
            exp_len_reg <= 8'd0;
            count_reg   <= 8'd0;
            csum_reg    <= 8'd0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            exp_len_reg <= exp_len_next;
            count_reg   <= count_next;
            csum_reg    <= csum_next;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            pvalid_reg <= pvalid_next;
            pbyte_reg  <= pbyte_next;
            pindex_reg <= pindex_next;
        end
    end

    // the state register already holds the phase after the last reported word
    assign out_valid      = out_valid_reg;
    assign frame_complete = (phase_reg == stxr_pkg::PH_DONE);
    assign frame_error    = (phase_reg == stxr_pkg::PH_ERROR);
    assign payload_valid  = pvalid_reg;
    assign payload_byte   = pbyte_reg;
    assign payload_index  = pindex_reg;
    assign phase          = phase_reg;

endmodule

// ===== rtl/stxr_checker.sv =====
module stxr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       frame_complete,
    input logic       frame_error,
    input logic       payload_valid,
    input logic [7:0] payload_byte,
    input logic [7:0] payload_index,
    input logic [2:0] phase
);

    // a stalled word stays on offer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word withdrawn while stalled");

    // a stalled word keeps its phase
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(phase))
        else $error("phase changed while stalled");

    // flags agree with the phase
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_complete == (phase == stxr_pkg::PH_DONE))
                   && (frame_error == (phase == stxr_pkg::PH_ERROR)))
        else $error("status flags disagree with phase");

    // payload only lands in data or checksum phase, otherwise data fields are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_valid |-> (phase == stxr_pkg::PH_DATA)
                                    || (phase == stxr_pkg::PH_CHECK))
        else $error("payload reported outside data phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !payload_valid |-> (payload_byte == 8'd0) && (payload_index == 8'd0))
        else $error("payload fields not cleared");

endmodule

bind stx_etx_frame_receiver_core stxr_checker u_stxr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_complete (frame_complete),
    .frame_error    (frame_error),
    .payload_valid  (payload_valid),
    .payload_byte   (payload_byte),
    .payload_index  (payload_index),
    .phase          (phase)
);

// ===== verif/stx_etx_frame_receiver_core_tb.sv =====
`timescale 1ns / 1ps

module stx_etx_frame_receiver_core_tb;

    localparam int unsigned WORD_TARGET  = 1300;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned LONG_HOLD    = 80;
    localparam int unsigned BIG_FRAMES   = 2;

    // kinds of damage applied to a generated frame
    typedef enum int unsigned {
        FAULT_NONE,
        FAULT_CHECKSUM,
        FAULT_END,
        FAULT_CUT
    } frame_fault_t;

    // one result word as seen on the output channel
    typedef struct packed {
        logic       frame_complete;
        logic       frame_error;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [2:0] phase;
    } rx_result_t;

    // frame parser prediction and queue of expected result words
    class frame_scoreboard;
        stxr_pkg::phase_t rx_phase;
        logic [7:0]       expected_length;
        logic [7:0]       received_count;
        logic [7:0]       running_checksum;
        rx_result_t       expected_q[$];
        int unsigned      error_count;

        function void clear_parser();
            rx_phase         = stxr_pkg::PH_START;
            expected_length  = '0;
            received_count   = '0;
            running_checksum = '0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // advance the parser by one accepted input word
        function void note_word(logic restart, logic [7:0] b);
            rx_result_t r;
            r = '0;
            if (restart)
            begin
                clear_parser();
            end
            else
            begin
                case (rx_phase)
                    stxr_pkg::PH_START:
                    begin
                        if (b == stxr_pkg::START_BYTE)
                        begin
                            running_checksum = b;
                            rx_phase = stxr_pkg::PH_LENGTH;
                        end
                    end
                    stxr_pkg::PH_LENGTH:
                    begin
                        expected_length  = b;
                        received_count   = '0;
                        running_checksum = running_checksum ^ b;
                        rx_phase = (b == 8'd0) ? stxr_pkg::PH_CHECK : stxr_pkg::PH_DATA;
                    end
                    stxr_pkg::PH_DATA:
                    begin
                        if (int'(received_count) < int'(stxr_pkg::MAX_PAYLOAD))
                        begin
                            r.payload_valid  = 1'b1;
                            r.payload_byte   = b;
                            r.payload_index  = received_count;
                            received_count   = received_count + 8'd1;
                            running_checksum = running_checksum ^ b;
                            if (received_count >= expected_length)
                                rx_phase = stxr_pkg::PH_CHECK;
                        end
                        else
                        begin
                            rx_phase = stxr_pkg::PH_ERROR;
                        end
                    end
                    stxr_pkg::PH_CHECK:
                        rx_phase = (running_checksum == b) ? stxr_pkg::PH_END
                                                           : stxr_pkg::PH_ERROR;
                    stxr_pkg::PH_END:
                        rx_phase = (b == stxr_pkg::END_BYTE) ? stxr_pkg::PH_DONE
                                                             : stxr_pkg::PH_ERROR;
                    stxr_pkg::PH_DONE:
                        ;
                    default:
                        rx_phase = stxr_pkg::PH_ERROR;
                endcase
            end
            r.frame_complete = (rx_phase == stxr_pkg::PH_DONE);
            r.frame_error    = (rx_phase == stxr_pkg::PH_ERROR);
            r.phase          = rx_phase;
            expected_q.push_back(r);
        endfunction

        // compare one accepted result word with the oldest expectation
        function void check_word(rx_result_t got);
            rx_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result word with no expectation waiting");
                error_count++;
                return;
            end
            want = expected_q.pop_front();
            if (got.frame_complete !== want.frame_complete)
            begin
                $error("frame_complete: expected %0d, got %0d",
                       want.frame_complete, got.frame_complete);
                error_count++;
            end
            if (got.frame_error !== want.frame_error)
            begin
                $error("frame_error: expected %0d, got %0d",
                       want.frame_error, got.frame_error);
                error_count++;
            end
            if (got.payload_valid !== want.payload_valid)
            begin
                $error("payload_valid: expected %0d, got %0d",
                       want.payload_valid, got.payload_valid);
                error_count++;
            end
            if (got.payload_byte !== want.payload_byte)
            begin
                $error("payload_byte: expected 0x%02h, got 0x%02h",
                       want.payload_byte, got.payload_byte);
                error_count++;
            end
            if (got.payload_index !== want.payload_index)
            begin
                $error("payload_index: expected %0d, got %0d",
                       want.payload_index, got.payload_index);
                error_count++;
            end
            if (got.phase !== want.phase)
            begin
                $error("phase: expected %0d, got %0d", want.phase, got.phase);
                error_count++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       mode;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic       frame_complete;
    logic       frame_error;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [2:0] phase;

    frame_scoreboard sb;
    int unsigned     words_sent;
    int unsigned     cycle_count;
    int unsigned     burst_left;
    bit              sender_steady;
    bit              long_hold_req;

    stx_etx_frame_receiver_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_complete (frame_complete),
        .frame_error    (frame_error),
        .payload_valid  (payload_valid),
        .payload_byte   (payload_byte),
        .payload_index  (payload_index),
        .phase          (phase)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watch both channels at every edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_word(mode, rx_byte);
            if (out_valid && !out_stall)
                sb.check_word({frame_complete, frame_error, payload_valid,
                               payload_byte, payload_index, phase});
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("stx_etx_frame_receiver_core_tb failed");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin : receiver_stall
        int unsigned span;
        int unsigned stall_pct;
        int unsigned hold_left;
        bit          hold_taken;
        span       = 0;
        stall_pct  = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        out_stall  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_taken && long_hold_req)
            begin
                hold_left  = LONG_HOLD;
                hold_taken = 1'b1;
            end
            if (span == 0)
            begin
                span = $urandom_range(10, 60);
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    default: stall_pct = 75;
                endcase
            end
            span--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // offer one word and wait until the block takes it
    task automatic send_word(logic restart, logic [7:0] b);
        int unsigned gap;
        if (!sender_steady && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        mode     <= restart;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    task automatic send_restart();
        send_word(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // one frame, optionally damaged or cut short by a restart
    task automatic send_frame(int unsigned len, frame_fault_t fault);
        logic [7:0]  cs;
        logic [7:0]  b;
        int unsigned cut;
        cs  = stxr_pkg::START_BYTE ^ 8'(len);
        cut = (fault == FAULT_CUT) ? $urandom_range(0, len + 2) : len + 3;
        send_word(1'b0, stxr_pkg::START_BYTE);
        if (cut == 0)
        begin
            send_restart();
            return;
        end
        send_word(1'b0, 8'(len));
        for (int unsigned i = 0; i < len; i++)
        begin
            if (cut == i + 1)
            begin
                send_restart();
                return;
            end
            b  = 8'($urandom_range(0, 255));
            cs = cs ^ b;
            send_word(1'b0, b);
        end
        if (cut == len + 1)
        begin
            send_restart();
            return;
        end
        if (fault == FAULT_CHECKSUM)
            send_word(1'b0, cs ^ 8'($urandom_range(1, 255)));
        else
            send_word(1'b0, cs);
        if (cut == len + 2)
        begin
            send_restart();
            return;
        end
        if (fault == FAULT_END)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == stxr_pkg::END_BYTE);
            send_word(1'b0, b);
        end
        else
        begin
            send_word(1'b0, stxr_pkg::END_BYTE);
        end
    endtask

    // stimulus
    initial
    begin : stimulus
        int unsigned  big_sent;
        int unsigned  len;
        int unsigned  pick;
        logic [7:0]   b;
        frame_fault_t fault;
        bit           hold_done;
        bit           drain_done;

        sb = new();
        sb.clear_parser();
        sb.error_count = 0;
        words_sent    = 0;
        burst_left    = 0;
        sender_steady = 1'b0;
        long_hold_req = 1'b0;
        big_sent      = 0;
        hold_done     = 1'b0;
        drain_done    = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        mode     = 1'b0;
        rx_byte  = 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: restart, idle noise, zero length frame, sticky done
        send_word(1'b1, 8'hFF);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, stxr_pkg::END_BYTE);
        send_word(1'b0, stxr_pkg::START_BYTE);
        send_word(1'b0, 8'h00);
        send_word(1'b0, stxr_pkg::START_BYTE);
        send_word(1'b0, stxr_pkg::END_BYTE);
        send_word(1'b0, 8'hFF);
        send_word(1'b1, 8'h00);
        // checksum mismatch, then sticky error
        send_word(1'b0, stxr_pkg::START_BYTE);
        send_word(1'b0, 8'h01);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'h00);
        send_word(1'b0, stxr_pkg::START_BYTE);
        send_word(1'b1, 8'h55);
        // good checksum, wrong end byte
        send_word(1'b0, stxr_pkg::START_BYTE);
        send_word(1'b0, 8'h02);
        send_word(1'b0, 8'hAA);
        send_word(1'b0, 8'h55);
        send_word(1'b0, stxr_pkg::START_BYTE ^ 8'h02 ^ 8'hAA ^ 8'h55);
        send_word(1'b0, 8'h04);
        send_word(1'b1, 8'hFF);
        drain_results();

        // random frames
        while (words_sent < WORD_TARGET)
        begin
            if (!hold_done && words_sent >= 400)
            begin
                hold_done     = 1'b1;
                long_hold_req = 1'b1;
                sender_steady = 1'b1;
            end
            if (sender_steady && words_sent >= 520)
                sender_steady = 1'b0;
            if (!drain_done && words_sent >= 800)
            begin
                drain_done = 1'b1;
                drain_results();
            end

            // line noise before the start byte
            repeat ($urandom_range(0, 3))
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == stxr_pkg::START_BYTE);
                send_word(1'b0, b);
            end

            pick = $urandom_range(0, 99);
            if (pick < 2 && big_sent < BIG_FRAMES)
            begin
                len = 255;
                big_sent++;
            end
            else if (pick < 12)
                len = 0;
            else if (pick < 20)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(1, 8);

            pick = $urandom_range(0, 99);
            if (pick < 70)
                fault = FAULT_NONE;
            else if (pick < 80)
                fault = FAULT_CHECKSUM;
            else if (pick < 90)
                fault = FAULT_END;
            else
                fault = FAULT_CUT;
            send_frame(len, fault);

            // bytes after the frame end are ignored while sticky
            if (fault != FAULT_CUT)
            begin
                repeat ($urandom_range(0, 2))
                    send_word(1'b0, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 99) < 95)
                    send_restart();
            end
        end

        // wind down
        drain_results();
        repeat (10) @(posedge clk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("stx_etx_frame_receiver_core_tb passed");
        else
            $display("stx_etx_frame_receiver_core_tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/stxr_pkg.sv
rtl/stx_etx_frame_receiver_core.sv
rtl/stxr_checker.sv
verif/stx_etx_frame_receiver_core_tb.sv
